### src/idea_pkg.sv
// ----------------------------------------------------------------------------
// IDEA encryption package
// Shared types, sizes and arithmetic helpers for the pipelined cipher.
// ----------------------------------------------------------------------------
package idea_pkg;

   localparam int ROUND_COUNT  = 8;
   localparam int SUBKEY_DEPTH = 6 * ROUND_COUNT + 4;
   localparam int KEY_ROTATE   = 25;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   typedef struct packed {
      logic [15:0] x1;
      logic [15:0] x2;
      logic [15:0] x3;
      logic [15:0] x4;
   } blk_type;

   // Subkey n: key rotated left by 25 bits per group of eight, word n%8 from the top.
   function automatic logic [15:0] subkey(input logic [127:0] key, input int n);
      logic [255:0] dbl;
      logic [127:0] rot;
      int           sh;
      int           w;
      sh  = (KEY_ROTATE * (n / 8)) % 128;
      dbl = {key, key} << sh;
      rot = dbl[255:128];
      w   = n % 8;
      return rot[(127 - 16 * w) -: 16];
   endfunction

   // Reduce a registered 16x16 product modulo 65537, zero standing for 65536.
   function automatic logic [15:0] mul_reduce(input logic [15:0] a, input logic [15:0] b,
                                              input logic [31:0] p);
      logic [15:0] lo;
      logic [15:0] hi;
      logic [15:0] r;
      lo = p[15:0];
      hi = p[31:16];
      if (a == 16'd0) begin
         r = 16'd1 - b;
      end else if (b == 16'd0) begin
         r = 16'd1 - a;
      end else begin
         r = lo - hi + {15'd0, (lo < hi)};
      end
      return r;
   endfunction

endpackage

### src/idea_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// IDEA block encrypt unit
// Pipelined IDEA encryption, one 64-bit word per cycle unless rsp stalls.
// ----------------------------------------------------------------------------
//  channel | direction | ports                        | content
//  req     | in        | req_tvalid/tready/tdata      | plaintext word
//  rsp     | out       | rsp_tvalid/tready/tdata      | ciphertext word
//  csr     | in        | csr_valid/ready/index/data   | key_high (0), key_low (1)
//
// One word enters each cycle while rsp is not stalled. Subkeys are fixed
// wiring of the key registers. Reset clears the valid bits and the key to
// zero. A stall on rsp freezes the whole pipeline; req_tready then drops.
module idea_block_encrypt_unit
   import idea_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // plain_block[63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cipher_block[63:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic [63:0] key_high_ff, key_low_ff;
   logic [127:0] key;
   logic         enable;
   logic         valid_q [0:ROUND_COUNT];
   blk_type      blk_q   [0:ROUND_COUNT];
   logic [3:0][15:0] out_keys;

   assign key       = {key_high_ff, key_low_ff};
   assign csr_ready = 1'b1;
   assign enable    = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign valid_q[0] = req_tvalid;
   assign blk_q[0]   = req_tdata;

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      logic [5:0][15:0] rk;
      for (genvar j = 0; j < 6; j++) begin : g_key
         assign rk[j] = subkey(key, 6 * r + j);
      end
      idea_round u_round (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_q[r]),
         .in_blk    (blk_q[r]),
         .keys      (rk),
         .out_valid (valid_q[r+1]),
         .out_blk   (blk_q[r+1])
      );
   end

   for (genvar j = 0; j < 4; j++) begin : g_out_key
      assign out_keys[j] = subkey(key, 6 * ROUND_COUNT + j);
   end

   idea_out_xform u_out (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (valid_q[ROUND_COUNT]),
      .in_blk    (blk_q[ROUND_COUNT]),
      .keys      (out_keys),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata)
   );

endmodule

### src/idea_round.sv
// ----------------------------------------------------------------------------
// IDEA round
// One full round in four register stages; A multiplies twice, B and C once.
// ----------------------------------------------------------------------------
module idea_round
   import idea_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  blk_type          in_blk,
   input  logic [5:0][15:0] keys,
   output logic             out_valid,
   output blk_type          out_blk
);

   logic [3:0]  valid_ff;
   // stage A
   logic [15:0] a1_ff, b1_ff, a4_ff, b4_ff, s2a_ff, s3a_ff;
   logic [31:0] p1_ff, p4_ff;
   // stage B
   logic [15:0] m1b_ff, m4b_ff, s2b_ff, s3b_ff, ub_ff, ta_ff, tb_ff;
   logic [31:0] tp_ff;
   // stage C
   logic [15:0] m1c_ff, m4c_ff, s2c_ff, s3c_ff, y3c_ff, va_ff, vb_ff;
   logic [31:0] vp_ff;
   blk_type     out_ff;

   logic [15:0] m1_in, m4_in, t_in, u_in, y3_in, v_in, y2_in, z3_in;

   always_comb begin
      m1_in = mul_reduce(a1_ff, b1_ff, p1_ff);
      m4_in = mul_reduce(a4_ff, b4_ff, p4_ff);
      t_in  = m1_in ^ s3a_ff;
      u_in  = s2a_ff ^ m4_in;
      y3_in = mul_reduce(ta_ff, tb_ff, tp_ff);
      v_in  = ub_ff + y3_in;
      y2_in = mul_reduce(va_ff, vb_ff, vp_ff);
      z3_in = y3c_ff + y2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff  <= in_blk.x1;
         b1_ff  <= keys[0];
         p1_ff  <= in_blk.x1 * keys[0];
         a4_ff  <= in_blk.x4;
         b4_ff  <= keys[3];
         p4_ff  <= in_blk.x4 * keys[3];
         s2a_ff <= in_blk.x2 + keys[1];
         s3a_ff <= in_blk.x3 + keys[2];

         m1b_ff <= m1_in;
         m4b_ff <= m4_in;
         s2b_ff <= s2a_ff;
         s3b_ff <= s3a_ff;
         ub_ff  <= u_in;
         ta_ff  <= t_in;
         tb_ff  <= keys[4];
         tp_ff  <= t_in * keys[4];

         m1c_ff <= m1b_ff;
         m4c_ff <= m4b_ff;
         s2c_ff <= s2b_ff;
         s3c_ff <= s3b_ff;
         y3c_ff <= y3_in;
         va_ff  <= v_in;
         vb_ff  <= keys[5];
         vp_ff  <= v_in * keys[5];

         out_ff.x1 <= m1c_ff ^ y2_in;
         out_ff.x4 <= m4c_ff ^ z3_in;
         out_ff.x2 <= y2_in ^ s3c_ff;
         out_ff.x3 <= z3_in ^ s2c_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_blk   = out_ff;

endmodule

### src/idea_out_xform.sv
// ----------------------------------------------------------------------------
// IDEA output transform
// Final key mixing in two stages; emits words in x1,x3,x2,x4 order.
// ----------------------------------------------------------------------------
module idea_out_xform
   import idea_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  blk_type          in_blk,
   input  logic [3:0][15:0] keys,
   output logic             out_valid,
   output logic [63:0]      out_data
);

   logic [1:0]  valid_ff;
   logic [15:0] a1_ff, b1_ff, a4_ff, b4_ff, s3_ff, s2_ff;
   logic [31:0] p1_ff, p4_ff;
   logic [63:0] data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_ff   <= in_blk.x1;
         b1_ff   <= keys[0];
         p1_ff   <= in_blk.x1 * keys[0];
         a4_ff   <= in_blk.x4;
         b4_ff   <= keys[3];
         p4_ff   <= in_blk.x4 * keys[3];
         s3_ff   <= in_blk.x3 + keys[1];
         s2_ff   <= in_blk.x2 + keys[2];
         data_ff <= {mul_reduce(a1_ff, b1_ff, p1_ff), s3_ff, s2_ff,
                     mul_reduce(a4_ff, b4_ff, p4_ff)};
      end
   end

   assign out_valid = valid_ff[1];
   assign out_data  = data_ff;

endmodule
